### hw/rtl/hpq_pkg.sv
// Binary heap priority queue: shared types, field widths and codes.
// Used by hpq_store, hpq_ctrl and the top level; depends on nothing.
`default_nettype none

package hpq_pkg;

  localparam int PRIO_W  = 16;
  localparam int KEY_W   = 16;
  localparam int ENTRY_W = PRIO_W + KEY_W;
  localparam int POS_W   = 8;
  localparam int OCC_W   = 9;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_UPDATE  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PRIO_W-1:0] priority_req;
    logic [KEY_W-1:0]  payload_key;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [PRIO_W-1:0] top_priority;
    logic [KEY_W-1:0]  top_key;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic min_first;
  } cfg_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_TOP,
    ST_EX_LAST,
    ST_UPD_RD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_PICK,
    ST_DN_CMP,
    ST_DONE
  } hpq_state_t;

endpackage

`default_nettype wire

### hw/rtl/hpq_chan_if.sv
// Valid/ready channel interface with a typed payload.
// Payload types come from hpq_pkg at instantiation.
`default_nettype none

interface hpq_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/hpq_store.sv
// Heap entry memory: one write port, one read port with registered data.
// Depends on hpq_pkg for the entry width.
`default_nettype none

module hpq_store #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [hpq_pkg::ENTRY_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic      [hpq_pkg::ENTRY_W-1:0] rdata
);

  logic [hpq_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [hpq_pkg::ENTRY_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data valid the cycle after the address
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/hpq_ctrl.sv
// Heap sequencer: operation decode, sift up and sift down over one shared
// priority comparator, entry count and result register.
// Depends on hpq_pkg; drives the ports of hpq_store.
`default_nettype none

module hpq_ctrl #(
  parameter int CAPACITY = 256,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        min_first,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire hpq_pkg::in_item_t           in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output hpq_pkg::out_item_t               out_item,
  output logic                             mem_we,
  output logic      [IDX_W-1:0]            mem_waddr,
  output logic      [hpq_pkg::ENTRY_W-1:0] mem_wdata,
  output logic      [IDX_W-1:0]            mem_raddr,
  input  wire logic [hpq_pkg::ENTRY_W-1:0] mem_rdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = IDX_W + 2;
  localparam int PW    = (CNT_W > hpq_pkg::POS_W) ? CNT_W : hpq_pkg::POS_W;
  localparam int OW    = (CNT_W > hpq_pkg::OCC_W) ? CNT_W : hpq_pkg::OCC_W;
  localparam int EW    = hpq_pkg::ENTRY_W;
  localparam int KW    = hpq_pkg::KEY_W;
  localparam int QW    = hpq_pkg::PRIO_W;

  hpq_pkg::hpq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;
  logic [EW-1:0]       ent_r, ent_nxt;
  logic [EW-1:0]       child_r, child_nxt;
  logic                down_r, down_nxt;
  logic [EW-1:0]       res_top_r, res_top_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  hpq_pkg::out_item_t  out_item_r, out_item_nxt;

  logic [IDX_W-1:0]    par_idx;
  logic [CW-1:0]       lft_idx, rgt_idx, n_ext;
  logic [PW-1:0]       pos_ext, cnt_pw;
  logic [CNT_W-1:0]    cnt_dec;
  logic [OW-1:0]       occ_ext;
  logic [QW-1:0]       cmp_a, cmp_b;
  logic                cmp_win;

  // Tree index arithmetic
  assign par_idx = (idx_r - IDX_W'(1)) >> 1;
  assign lft_idx = (CW'(idx_r) << 1) + CW'(1);
  assign rgt_idx = lft_idx + CW'(1);
  assign n_ext   = CW'(count_r);
  assign pos_ext = PW'(in_item.position);
  assign cnt_pw  = PW'(count_r);
  assign cnt_dec = count_r - CNT_W'(1);
  assign occ_ext = OW'(count_r);

  // Select operands of the shared comparator
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state_r)
      hpq_pkg::ST_UP_CMP: begin
        cmp_a = ent_r[EW-1:KW];
        cmp_b = mem_rdata[EW-1:KW];
      end
      hpq_pkg::ST_DN_PICK: begin
        cmp_a = child_r[EW-1:KW];
        cmp_b = mem_rdata[EW-1:KW];
      end
      hpq_pkg::ST_DN_CMP: begin
        cmp_a = child_r[EW-1:KW];
        cmp_b = ent_r[EW-1:KW];
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // True when operand a strictly outranks operand b
  assign cmp_win = min_first ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    ent_nxt        = ent_r;
    child_nxt      = child_r;
    down_nxt       = down_r;
    res_top_nxt    = res_top_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = ent_r;
    mem_raddr      = '0;
    in_ready       = (state_r == hpq_pkg::ST_IDLE);

    unique case (state_r)
      hpq_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_top_nxt    = '0;
          res_status_nxt = hpq_pkg::STATUS_OK;
          down_nxt       = 1'b0;
          unique case (in_item.kind)
            hpq_pkg::KIND_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = hpq_pkg::STATUS_FULL;
                state_nxt      = hpq_pkg::ST_DONE;
              end else begin
                ent_nxt   = {in_item.priority_req, in_item.payload_key};
                idx_nxt   = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
                state_nxt = hpq_pkg::ST_UP_RD;
              end
            end
            hpq_pkg::KIND_EXTRACT: begin
              if (count_r == '0) begin
                res_status_nxt = hpq_pkg::STATUS_EMPTY;
                state_nxt      = hpq_pkg::ST_DONE;
              end else begin
                mem_raddr = '0;
                state_nxt = hpq_pkg::ST_EX_TOP;
              end
            end
            hpq_pkg::KIND_UPDATE: begin
              if (pos_ext >= cnt_pw) begin
                res_status_nxt = hpq_pkg::STATUS_BAD;
                state_nxt      = hpq_pkg::ST_DONE;
              end else begin
                mem_raddr = pos_ext[IDX_W-1:0];
                idx_nxt   = pos_ext[IDX_W-1:0];
                ent_nxt   = {in_item.priority_req, {KW{1'b0}}};
                state_nxt = hpq_pkg::ST_UPD_RD;
              end
            end
            default: begin
              state_nxt = hpq_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Capture the root as the result, fetch the last entry
      hpq_pkg::ST_EX_TOP: begin
        res_top_nxt = mem_rdata;
        count_nxt   = cnt_dec;
        mem_raddr   = cnt_dec[IDX_W-1:0];
        state_nxt   = hpq_pkg::ST_EX_LAST;
      end

      // Hold the last entry and sift it down from the root unless the heap is now empty
      hpq_pkg::ST_EX_LAST: begin
        ent_nxt   = mem_rdata;
        idx_nxt   = '0;
        state_nxt = (count_r == '0) ? hpq_pkg::ST_DONE : hpq_pkg::ST_DN_RDL;
      end

      // Keep the stored key, then try up and fall back to down
      hpq_pkg::ST_UPD_RD: begin
        ent_nxt   = {ent_r[EW-1:KW], mem_rdata[KW-1:0]};
        down_nxt  = 1'b1;
        state_nxt = hpq_pkg::ST_UP_RD;
      end

      hpq_pkg::ST_UP_RD: begin
        if (idx_r == '0) begin
          if (down_r) begin
            state_nxt = hpq_pkg::ST_DN_RDL;
          end else begin
            mem_we    = 1'b1;
            state_nxt = hpq_pkg::ST_DONE;
          end
        end else begin
          mem_raddr = par_idx;
          state_nxt = hpq_pkg::ST_UP_CMP;
        end
      end

      // Move the parent down a level or settle the held entry
      hpq_pkg::ST_UP_CMP: begin
        if (cmp_win) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          idx_nxt   = par_idx;
          down_nxt  = 1'b0;
          state_nxt = hpq_pkg::ST_UP_RD;
        end else if (down_r) begin
          state_nxt = hpq_pkg::ST_DN_RDL;
        end else begin
          mem_we    = 1'b1;
          state_nxt = hpq_pkg::ST_DONE;
        end
      end

      hpq_pkg::ST_DN_RDL: begin
        if (lft_idx >= n_ext) begin
          mem_we    = 1'b1;
          state_nxt = hpq_pkg::ST_DONE;
        end else begin
          mem_raddr = lft_idx[IDX_W-1:0];
          state_nxt = hpq_pkg::ST_DN_RDR;
        end
      end

      // Hold the left child, fetch the right one if it exists
      hpq_pkg::ST_DN_RDR: begin
        child_nxt = mem_rdata;
        pick_nxt  = lft_idx[IDX_W-1:0];
        if (rgt_idx < n_ext) begin
          mem_raddr = rgt_idx[IDX_W-1:0];
          state_nxt = hpq_pkg::ST_DN_PICK;
        end else begin
          state_nxt = hpq_pkg::ST_DN_CMP;
        end
      end

      // Left wins only when it strictly outranks the right
      hpq_pkg::ST_DN_PICK: begin
        if (!cmp_win) begin
          child_nxt = mem_rdata;
          pick_nxt  = rgt_idx[IDX_W-1:0];
        end
        state_nxt = hpq_pkg::ST_DN_CMP;
      end

      // Move the chosen child up a level or settle the held entry
      hpq_pkg::ST_DN_CMP: begin
        mem_we = 1'b1;
        if (cmp_win) begin
          mem_wdata = child_r;
          idx_nxt   = pick_r;
          state_nxt = hpq_pkg::ST_DN_RDL;
        end else begin
          state_nxt = hpq_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register once it is free
      hpq_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.top_priority = res_top_r[EW-1:KW];
          out_item_nxt.top_key      = res_top_r[KW-1:0];
          out_item_nxt.status       = res_status_r;
          out_item_nxt.occupancy    = occ_ext[hpq_pkg::OCC_W-1:0];
          state_nxt                 = hpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hpq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    ent_r        <= ent_nxt;
    child_r      <= child_nxt;
    down_r       <= down_nxt;
    res_top_r    <= res_top_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### hw/rtl/binary_heap_priority_queue.sv
// Binary heap priority queue top level: mode register, sequencer, heap memory.
// Depends on hpq_pkg, hpq_chan_if, hpq_ctrl and hpq_store.
//
//   channel  dir  payload      transaction
//   in_ch    in   in_item_t    one operation: insert, extract or update
//   out_ch   out  out_item_t   one result per operation
//   cfg_ch   in   cfg_item_t   write of min_first, always ready
//
// Each sift-up level costs one read of the single memory port plus one pass
// through the shared comparator; sift down reads up to two children per level.
// in_ch is ready only while the sequencer is idle; a finished result waits in
// the output register and a new operation is taken meanwhile.
// Synchronous active-low reset empties the heap and clears min_first.
`default_nettype none

module binary_heap_priority_queue #(
  parameter int CAPACITY = 256
) (
  input wire logic   clk,
  input wire logic   rst_n,
  hpq_chan_if.sink   in_ch,
  hpq_chan_if.source out_ch,
  hpq_chan_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                        min_first_r;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [hpq_pkg::ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]            mem_raddr;
  logic [hpq_pkg::ENTRY_W-1:0] mem_rdata;
  hpq_pkg::in_item_t           in_item;
  hpq_pkg::out_item_t          out_item;
  hpq_pkg::cfg_item_t          cfg_item;

  assign in_item  = in_ch.data;
  assign cfg_item = cfg_ch.data;

  // Mode register, written on a cfg transaction
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_first_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      min_first_r <= cfg_item.min_first;
    end
  end

  hpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_first (min_first_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign out_ch.data = out_item;

  hpq_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
